@@ design/pwm_pkg.sv @@
// Package for the motif site scanner: operation codes, base codes and
// the states of the scoring back part.
`timescale 1ns / 1ps
package pwm_pkg;
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BASE  = 2'd1,
    OP_WLOAD = 2'd2,
    OP_HLOAD = 2'd3
  } op_e;

  localparam logic [2:0] CODE_N = 3'd4;
  localparam logic [2:0] CODE_T = 3'd3;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SETUP,
    BK_SCORE,
    BK_DRAIN,
    BK_EMIT
  } bk_state_e;
endpackage

@@ design/pwm_front.sv @@
// Front part: takes input words, keeps the position and the fill count.
// Weight loads and base jobs are pushed into a two-entry queue. Depends on pwm_pkg.
`timescale 1ns / 1ps
module pwm_front import pwm_pkg::*; #(
  parameter int MAX_MOTIFS = 8,
  parameter int MAX_LEN = 32,
  parameter int POS_BITS = 20,
  localparam int SW = (MAX_MOTIFS > 1) ? $clog2(MAX_MOTIFS) : 1,
  localparam int RW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
  localparam int FW = $clog2(MAX_LEN + 1),
  localparam int QW = 1 + SW + RW + 2 + 16 + 3 + POS_BITS + FW
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     op_i,
  input  logic [2:0]     symbol_i,
  input  logic [2:0]     motif_slot_i,
  input  logic [4:0]     row_i,
  input  logic signed [15:0] weight_i,
  input  logic           hdr_block_i,
  output logic           q_valid_o,
  input  logic           q_pop_i,
  output logic [QW-1:0]  q_word_o
);
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [QW-1:0] q_mem_q [2];
  logic q_wp_q, q_rp_q;
  logic [1:0] q_cnt_q;
  logic acc, push;
  logic [QW-1:0] word;
  logic wl_ok;

  // hold header words until the back part is idle
  assign in_stall = (q_cnt_q == 2'd2) || ((op_i == OP_HLOAD) && hdr_block_i);
  assign acc = in_valid && !in_stall;
  assign wl_ok = (symbol_i <= CODE_T) && (32'(row_i) < MAX_LEN)
                 && (32'(motif_slot_i) < MAX_MOTIFS);
  assign push = acc && ((op_i == OP_BASE) || ((op_i == OP_WLOAD) && wl_ok));
  assign word = {(op_i == OP_BASE), SW'(motif_slot_i), RW'(row_i), symbol_i[1:0],
                 weight_i, symbol_i, pos_q, fill_d};

  always_comb begin
    pos_d = pos_q;
    fill_d = fill_q;
    if (acc && op_i == OP_START) begin
      pos_d = '0;
      fill_d = '0;
    end else if (acc && op_i == OP_BASE) begin
      pos_d = pos_q + 1'b1;
      if (32'(fill_q) < MAX_LEN) fill_d = fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      fill_q <= '0;
      q_wp_q <= 1'b0;
      q_rp_q <= 1'b0;
      q_cnt_q <= '0;
    end else begin
      pos_q <= pos_d;
      fill_q <= fill_d;
      if (push) q_wp_q <= ~q_wp_q;
      if (q_pop_i) q_rp_q <= ~q_rp_q;
      q_cnt_q <= q_cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[q_wp_q] <= word;
  end

  assign q_valid_o = (q_cnt_q != 2'd0);
  assign q_word_o = q_mem_q[q_rp_q];
endmodule

@@ design/pwm_back.sv @@
// Back part: window, weight memory, motif headers and the serial scorer.
// Pops queue words, scores each motif one row per cycle, emits sites. Depends on pwm_pkg.
`timescale 1ns / 1ps
module pwm_back import pwm_pkg::*; #(
  parameter int MAX_MOTIFS = 8,
  parameter int MAX_LEN = 32,
  parameter int POS_BITS = 20,
  localparam int SW = (MAX_MOTIFS > 1) ? $clog2(MAX_MOTIFS) : 1,
  localparam int RW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
  localparam int FW = $clog2(MAX_LEN + 1),
  localparam int QW = 1 + SW + RW + 2 + 16 + 3 + POS_BITS + FW,
  localparam int AW = SW + RW + 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [3:0]     active_i,
  input  logic           q_valid_i,
  output logic           q_pop_o,
  input  logic [QW-1:0]  q_word_i,
  input  logic           hdr_we_i,
  input  logic [2:0]     hdr_slot_i,
  input  logic [5:0]     hdr_len_i,
  input  logic signed [23:0] hdr_best_i,
  input  logic [15:0]    hdr_thr_i,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [19:0]    start_pos_o,
  output logic           strand_o,
  output logic [2:0]     motif_id_o,
  output logic signed [23:0] energy_o,
  output logic           last_o,
  output logic           busy_o
);
  localparam int MW = (MAX_MOTIFS < 8) ? MAX_MOTIFS : 8;

  logic q_isbase;
  logic [SW-1:0] q_slot;
  logic [RW-1:0] q_row;
  logic [1:0] q_col;
  logic signed [15:0] q_wt;
  logic [2:0] q_sym;
  logic [POS_BITS-1:0] q_pos;
  logic [FW-1:0] q_fill;
  assign {q_isbase, q_slot, q_row, q_col, q_wt, q_sym, q_pos, q_fill} = q_word_i;

  logic [2:0] win_q [MAX_LEN];
  logic [FW-1:0] len_q [MAX_MOTIFS];
  logic signed [23:0] best_q [MAX_MOTIFS];
  logic signed [39:0] lim_q [MAX_MOTIFS];
  logic signed [15:0] wmem [2**AW];
  logic signed [15:0] rd_f_q, rd_r_q;

  bk_state_e st_q, st_d;
  logic [SW-1:0] k_q;
  logic [3:0] kc_q;
  logic [RW:0] i_q;
  logic rd_v_q, bad_q, fwd_done_q;
  logic signed [31:0] sf_q, sr_q;
  logic [POS_BITS-1:0] pos_q;
  logic [FW-1:0] fill_q;
  logic [3:0] nmot;
  logic [FW-1:0] klen;
  logic k_ok;
  logic signed [40:0] ef, er;
  logic hit_f, hit_r;
  logic [3:0] kn;

  // output register
  logic ov_q, ostr_q, olast_q;
  logic [19:0] ostart_q;
  logic [2:0] oid_q;
  logic signed [23:0] oen_q;

  // held site: goes out once the next site or the end of the base is known
  logic pend_v_q, pend_str_q;
  logic [19:0] pend_start_q;
  logic [2:0] pend_id_q;
  logic signed [23:0] pend_en_q;

  assign nmot = (32'(active_i) > MW) ? 4'(MW) : active_i;
  assign klen = len_q[k_q];
  assign k_ok = (klen != '0) && (klen <= fill_q) && (kc_q < nmot);
  assign ef = 41'(best_q[k_q]) - 41'(sf_q);
  assign er = 41'(best_q[k_q]) - 41'(sr_q);
  assign hit_f = !bad_q && ((ef <<< 8) <= 41'(lim_q[k_q]));
  assign hit_r = !bad_q && ((er <<< 8) <= 41'(lim_q[k_q]));
  assign kn = kc_q + 4'd1;

  function automatic logic [23:0] sat24(input logic signed [40:0] v);
    if (v > 41'sd8388607) return 24'h7FFFFF;
    if (v < -41'sd8388608) return 24'h800000;
    return v[23:0];
  endfunction

  logic emit_f, emit_r;
  logic fire_ok, out_load, ov_d;
  assign fire_ok = !ov_q || !out_stall;

  always_comb begin
    st_d = st_q;
    case (st_q)
      BK_IDLE:  if (q_valid_i && q_isbase) st_d = BK_SETUP;
      BK_SETUP: st_d = (kc_q < nmot) ? BK_SCORE : BK_DRAIN;
      BK_SCORE: begin
        if (!k_ok) st_d = BK_SETUP;
        else if (i_q == (RW+1)'(klen) && !rd_v_q) st_d = BK_EMIT;
      end
      BK_EMIT:  if (fire_ok && fwd_done_q) st_d = BK_SETUP;
      BK_DRAIN: if (!pend_v_q || fire_ok) st_d = BK_IDLE;
      default:  st_d = BK_IDLE;
    endcase
  end

  assign q_pop_o = (st_q == BK_IDLE) && q_valid_i;
  assign busy_o = (st_q != BK_IDLE) || q_valid_i;

  // emit decisions in BK_EMIT: forward first, then reverse
  always_comb begin
    emit_f = (st_q == BK_EMIT) && !fwd_done_q && hit_f;
    emit_r = (st_q == BK_EMIT) && fwd_done_q && hit_r;
  end

  assign out_load = pend_v_q && fire_ok && (emit_f || emit_r || (st_q == BK_DRAIN));
  assign ov_d = out_load ? 1'b1 : (out_stall ? ov_q : 1'b0);

  logic [RW:0] rd_idx;
  logic [2:0] bf, br;
  assign rd_idx = (RW+1)'(klen) - 1'b1 - i_q;
  assign bf = win_q[rd_idx[RW-1:0]];
  assign br = CODE_T - win_q[i_q[RW-1:0]];

  always_ff @(posedge clk_i) begin
    if (q_pop_o && !q_isbase) wmem[{q_slot, q_row, q_col}] <= q_wt;
    rd_f_q <= wmem[{k_q, i_q[RW-1:0], bf[1:0]}];
    rd_r_q <= wmem[{k_q, i_q[RW-1:0], br[1:0]}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE;
      for (int j = 0; j < MAX_LEN; j++) win_q[j] <= CODE_N;
      for (int j = 0; j < MAX_MOTIFS; j++) begin
        len_q[j] <= '0;
        best_q[j] <= '0;
        lim_q[j] <= '0;
      end
      k_q <= '0; kc_q <= '0; i_q <= '0; rd_v_q <= 1'b0; bad_q <= 1'b0;
      fwd_done_q <= 1'b0; sf_q <= '0; sr_q <= '0; pos_q <= '0; fill_q <= '0;
      ov_q <= 1'b0; ostr_q <= 1'b0; olast_q <= 1'b0; ostart_q <= '0;
      oid_q <= '0; oen_q <= '0;
      pend_v_q <= 1'b0; pend_str_q <= 1'b0; pend_start_q <= '0;
      pend_id_q <= '0; pend_en_q <= '0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
      if (out_load) begin
        ostart_q <= pend_start_q;
        ostr_q <= pend_str_q;
        oid_q <= pend_id_q;
        oen_q <= pend_en_q;
        olast_q <= (st_q == BK_DRAIN);
      end
      if (hdr_we_i && 32'(hdr_slot_i) < MAX_MOTIFS) begin
        len_q[SW'(hdr_slot_i)] <= (32'(hdr_len_i) > MAX_LEN) ? FW'(MAX_LEN)
                                                             : FW'(hdr_len_i);
        best_q[SW'(hdr_slot_i)] <= hdr_best_i;
        lim_q[SW'(hdr_slot_i)] <= 40'(hdr_best_i) * $signed({1'b0, hdr_thr_i});
      end
      case (st_q)
        BK_IDLE: if (q_pop_o && q_isbase) begin
          for (int j = MAX_LEN - 1; j > 0; j--) win_q[j] <= win_q[j-1];
          win_q[0] <= q_sym;
          pos_q <= q_pos;
          fill_q <= q_fill;
          kc_q <= '0;
          k_q <= '0;
        end
        BK_SETUP: begin
          i_q <= '0; rd_v_q <= 1'b0; bad_q <= 1'b0; sf_q <= '0; sr_q <= '0;
          fwd_done_q <= 1'b0;
        end
        BK_SCORE: if (!k_ok) begin
          kc_q <= kn; k_q <= SW'(kn);
        end else begin
          if (rd_v_q) begin
            sf_q <= sf_q + 32'(rd_f_q);
            sr_q <= sr_q + 32'(rd_r_q);
          end
          if (i_q != (RW+1)'(klen)) begin
            if (win_q[i_q[RW-1:0]] > CODE_T) bad_q <= 1'b1;
            i_q <= i_q + 1'b1;
            rd_v_q <= 1'b1;
          end else rd_v_q <= 1'b0;
        end
        BK_EMIT: if (fire_ok) begin
          if (emit_f || emit_r) begin
            pend_v_q <= 1'b1;
            pend_start_q <= 20'(pos_q - POS_BITS'(klen) + 1'b1);
            pend_str_q <= emit_f;
            pend_id_q <= 3'(k_q);
            pend_en_q <= sat24(emit_f ? ef : er);
          end
          if (!fwd_done_q) fwd_done_q <= 1'b1;
          else begin
            kc_q <= kn; k_q <= SW'(kn);
          end
        end
        BK_DRAIN: if (fire_ok) pend_v_q <= 1'b0;
        default: ;
      endcase
    end
  end

  assign out_valid = ov_q;
  assign start_pos_o = ostart_q;
  assign strand_o = ostr_q;
  assign motif_id_o = oid_q;
  assign energy_o = oen_q;
  assign last_o = olast_q;
endmodule

@@ design/pwm_motif_site_scanner.sv @@
// Top level of the motif site scanner: front part, queue and scoring back part.
// Back part per base: a setup for each motif slot, a scoring pass over the rows of each
// scored motif and an emit step, forward then reverse; a skipped slot goes back to setup.
// Each site is held until the next one, so a base's last site leaves after its scan.
// Header loads stall while the back part is busy.
// Reset is asynchronous, active low; window reads N, headers and position clear.
`timescale 1ns / 1ps
module pwm_motif_site_scanner import pwm_pkg::*; #(
  parameter int MAX_MOTIFS = 8,
  parameter int MAX_LEN = 32,
  parameter int POS_BITS = 20
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] op_i,
  input  logic [2:0] symbol_i,
  input  logic [2:0] motif_slot_i,
  input  logic [4:0] row_i,
  input  logic signed [15:0] weight_i,
  input  logic [5:0] motif_len_i,
  input  logic signed [23:0] max_score_i,
  input  logic [15:0] thr_factor_i,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [3:0] cfg_data_i,
  output logic out_valid,
  input  logic out_stall,
  output logic [19:0] start_pos_o,
  output logic strand_o,
  output logic [2:0] motif_id_o,
  output logic signed [23:0] energy_o,
  output logic last_o
);
  localparam int SW = (MAX_MOTIFS > 1) ? $clog2(MAX_MOTIFS) : 1;
  localparam int RW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int FW = $clog2(MAX_LEN + 1);
  localparam int QW = 1 + SW + RW + 2 + 16 + 3 + POS_BITS + FW;

  logic [3:0] active_q;
  logic q_valid, q_pop, busy;
  logic [QW-1:0] q_word;
  logic hdr_we;
  logic front_stall;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) active_q <= '0;
    else if (cfg_valid && cfg_ready) active_q <= cfg_data_i;
  end

  // header writes bypass the queue; the front part holds them while the back part is busy
  assign hdr_we = in_valid && !in_stall && (op_i == OP_HLOAD);
  assign front_stall = busy;

  pwm_front #(.MAX_MOTIFS(MAX_MOTIFS), .MAX_LEN(MAX_LEN), .POS_BITS(POS_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .op_i, .symbol_i, .motif_slot_i, .row_i,
    .weight_i, .hdr_block_i(front_stall),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_word_o(q_word)
  );

  pwm_back #(.MAX_MOTIFS(MAX_MOTIFS), .MAX_LEN(MAX_LEN), .POS_BITS(POS_BITS)) u_back (
    .clk_i, .rst_ni, .active_i(active_q), .q_valid_i(q_valid), .q_pop_o(q_pop),
    .q_word_i(q_word), .hdr_we_i(hdr_we), .hdr_slot_i(motif_slot_i),
    .hdr_len_i(motif_len_i), .hdr_best_i(max_score_i), .hdr_thr_i(thr_factor_i),
    .out_valid, .out_stall, .start_pos_o, .strand_o, .motif_id_o, .energy_o, .last_o,
    .busy_o(busy)
  );

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(energy_o))
    else $error("site word dropped under stall");
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid |-> front_stall)
    else $error("queue word without busy back part");
endmodule

@@ dv/pwm_motif_site_scanner_tb.sv @@
// Self-checking bench for the motif site scanner: predicts each site from the
// item stream and checks the result words in order. Depends on pwm_pkg.
`timescale 1ns / 1ps
module pwm_motif_site_scanner_tb;
  import pwm_pkg::*;

  localparam int ROWS = 6;

  typedef struct packed {
    op_e         op;
    logic [2:0]  symbol;
    logic [2:0]  slot;
    logic [4:0]  row;
    logic [15:0] weight;
    logic [5:0]  len;
    logic [23:0] best;
    logic [15:0] thr;
  } item_t;

  typedef struct packed {
    logic [19:0] start_pos;
    logic        strand;
    logic [2:0]  motif_id;
    logic [23:0] energy;
    logic        last;
  } site_t;

  logic clk_i = 0, rst_ni = 0;
  logic in_valid = 0, cfg_valid = 0, out_stall = 0;
  logic [1:0] op_i = 0;
  logic [2:0] symbol_i = 0, motif_slot_i = 0;
  logic [4:0] row_i = 0;
  logic signed [15:0] weight_i = 0;
  logic [5:0] motif_len_i = 0;
  logic signed [23:0] max_score_i = 0;
  logic [15:0] thr_factor_i = 0;
  logic [3:0] cfg_data_i = 0;
  logic in_stall, cfg_ready, out_valid, strand_o, last_o;
  logic [19:0] start_pos_o;
  logic [2:0] motif_id_o;
  logic signed [23:0] energy_o;

  pwm_motif_site_scanner uut (.*);

  item_t pending_items[$];
  site_t expected_sites[$];
  int errors = 0;
  bit calm = 0;

  logic [2:0] window[32];
  int unsigned fill;
  logic [19:0] pos;
  logic signed [15:0] weights[8][32][4];
  int unsigned mlen[8];
  longint best_sc[8], e_limit[8];
  int unsigned n_active;

  initial forever #5 clk_i = ~clk_i;

  function automatic logic [23:0] sat24(longint e);
    if (e > 8388607) return 24'h7FFFFF;
    if (e < -8388608) return 24'h800000;
    return e[23:0];
  endfunction

  task automatic add_item(item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic add_site(site_t s);
    expected_sites.insert(expected_sites.size(), s);
  endtask

  task automatic predict_sites(item_t it);
    int n;
    longint fwd, rev, e;
    bit ok;
    logic [19:0] idx;
    logic [19:0] st;
    n = expected_sites.size();
    case (it.op)
      OP_START: begin
        foreach (window[i]) window[i] = CODE_N;
        fill = 0; pos = 0;
      end
      OP_WLOAD:
        if (it.symbol <= CODE_T) weights[it.slot][it.row][it.symbol] = it.weight;
      OP_HLOAD: begin
        mlen[it.slot] = it.len > 32 ? 32 : it.len;
        best_sc[it.slot] = longint'($signed(it.best));
        e_limit[it.slot] = best_sc[it.slot] * longint'(it.thr);
      end
      default: begin
        for (int i = 31; i > 0; i--) window[i] = window[i-1];
        window[0] = it.symbol;
        if (fill < 32) fill++;
        idx = pos; pos = pos + 20'd1;
        for (int k = 0; k < (n_active > 8 ? 8 : n_active); k++) begin
          if (mlen[k] == 0 || mlen[k] > fill) continue;
          ok = 1;
          for (int i = 0; i < mlen[k]; i++) if (window[i] > CODE_T) ok = 0;
          if (!ok) continue;
          fwd = 0; rev = 0;
          for (int i = 0; i < mlen[k]; i++) begin
            fwd += weights[k][i][window[mlen[k]-1-i][1:0]];
            rev += weights[k][i][2'd3 - window[i][1:0]];
          end
          st = idx - 20'(mlen[k]) + 20'd1;
          e = best_sc[k] - fwd;
          if (e * 256 <= e_limit[k]) add_site('{st, 1'b1, 3'(k), sat24(e), 1'b0});
          e = best_sc[k] - rev;
          if (e * 256 <= e_limit[k]) add_site('{st, 1'b0, 3'(k), sat24(e), 1'b0});
        end
        if (expected_sites.size() > n)
          expected_sites[expected_sites.size()-1].last = 1'b1;
      end
    endcase
  endtask

  // driver
  always @(posedge clk_i) begin
    item_t it;
    if (in_valid && !in_stall) begin
      void'(pending_items.pop_front());
      predict_sites(item_t'({op_i, symbol_i, motif_slot_i, row_i, weight_i,
                             motif_len_i, max_score_i, thr_factor_i}));
    end
    if (rst_ni && (!in_valid || !in_stall)) begin
      if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 35)) begin
        it = pending_items[0];
        in_valid <= 1;
        op_i <= it.op; symbol_i <= it.symbol; motif_slot_i <= it.slot;
        row_i <= it.row; weight_i <= it.weight; motif_len_i <= it.len;
        max_score_i <= it.best; thr_factor_i <= it.thr;
      end else
        in_valid <= 0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    site_t got, exp_s;
    if (rst_ni) out_stall <= !calm && $urandom_range(99) < 35;
    if (out_valid && !out_stall) begin
      got = '{start_pos_o, strand_o, motif_id_o, energy_o, last_o};
      if (expected_sites.size() == 0) begin
        $error("unexpected site %p", got); errors++;
      end else begin
        exp_s = expected_sites.pop_front();
        if (got.start_pos !== exp_s.start_pos) begin
          $error("start_pos exp %0d got %0d", exp_s.start_pos, got.start_pos); errors++; end
        if (got.strand !== exp_s.strand) begin
          $error("strand exp %0d got %0d", exp_s.strand, got.strand); errors++; end
        if (got.motif_id !== exp_s.motif_id) begin
          $error("motif_id exp %0d got %0d", exp_s.motif_id, got.motif_id); errors++; end
        if (got.energy !== exp_s.energy) begin
          $error("energy exp %0d got %0d", $signed(exp_s.energy), $signed(got.energy));
          errors++; end
        if (got.last !== exp_s.last) begin
          $error("last exp %0d got %0d", exp_s.last, got.last); errors++; end
      end
    end
  end

  function automatic item_t mk(op_e op, int sym = 0, int slot = 0, int row = 0,
                               int w = 0, int len = 0, int b = 0, int thr = 0);
    return '{op, 3'(sym), 3'(slot), 5'(row), 16'(w), 6'(len), 24'(b), 16'(thr)};
  endfunction

  task automatic settle();
    while (pending_items.size() > 0 || in_valid || expected_sites.size() > 0)
      @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_active(int v);
    @(posedge clk_i);
    cfg_valid <= 1; cfg_data_i <= 4'(v);
    do @(posedge clk_i); while (!cfg_ready);
    n_active = v;
    cfg_valid <= 0;
  endtask

  // load the weights of the rows in use for a slot, then its header
  task automatic load_motif(int slot, int len, int wmax, int best, int thr);
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < 4; c++)
        add_item(mk(OP_WLOAD, c, slot, r, $urandom_range(2*wmax) - wmax));
    add_item(mk(OP_HLOAD, 0, slot, 0, 0, len, best, thr));
  endtask

  task automatic push_bases(int n, int noisy);
    for (int i = 0; i < n; i++)
      add_item(mk(OP_BASE, ($urandom_range(99) < noisy) ?
                           $urandom_range(4, 7) : $urandom_range(3)));
  endtask

  initial begin
    foreach (window[i]) window[i] = CODE_N;
    fill = 0; pos = 0; n_active = 0;
    foreach (mlen[k]) begin mlen[k] = 0; best_sc[k] = 0; e_limit[k] = 0; end
    foreach (weights[s, r, c]) weights[s][r][c] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    // directed: weights first so no base ever reads an unwritten entry
    for (int s = 0; s < 8; s++) load_motif(s, 1 + s % ROWS, 256, 0, 0);
    settle();
    write_active(8);
    add_item(mk(OP_WLOAD, 0, 0, 0, -32768));
    add_item(mk(OP_WLOAD, 3, 0, 0, 32767));
    add_item(mk(OP_WLOAD, 5, 1, 3, 77));
    add_item(mk(OP_HLOAD, 0, 0, 0, 0, 1, -8388608, 65535));
    add_item(mk(OP_HLOAD, 0, 1, 0, 0, 2, 8388607, 65535));
    add_item(mk(OP_HLOAD, 0, 2, 0, 0, 63, 8388607, 0));
    add_item(mk(OP_HLOAD, 0, 3, 0, 0, 0, 100, 300));
    add_item(mk(OP_START));
    for (int b = 0; b < 8; b++) add_item(mk(OP_BASE, b));
    for (int b = 0; b < 4; b++) add_item(mk(OP_BASE, b));
    add_item(mk(OP_START));
    for (int b = 0; b < 3; b++) add_item(mk(OP_BASE, 3 - b));
    settle();
    // random phases over several settings of the active count; runs stay below
    // 32 bases so over-long motifs never read past the loaded rows
    for (int ph = 0; ph < 6; ph++) begin
      write_active(ph == 0 ? 0 : ph == 1 ? 15 : ph == 2 ? 1 : $urandom_range(2, 9));
      for (int s = 0; s < 8; s++)
        add_item(mk(OP_HLOAD, 0, s, 0, 0,
          $urandom_range(99) < 80 ? $urandom_range(1, ROWS)
                                  : ($urandom_range(1) ? 0 : $urandom_range(33, 63)),
          $urandom_range(99) < 70 ? $urandom_range(2000) - 1000
                                  : $urandom_range(16777215),
          $urandom_range(99) < 70 ? $urandom_range(200, 600) : $urandom_range(65535)));
      if (ph == 3) load_motif($urandom_range(7), 0, 32768, 0, 0);
      if (ph == 3) add_item(mk(OP_HLOAD, 0, 0, 0, 0, 4, 0, 400));
      add_item(mk(OP_START));
      calm = (ph == 4);
      push_bases(24, 8);
      add_item(mk(OP_WLOAD, $urandom_range(4, 7), $urandom_range(7),
                  $urandom_range(31), $urandom_range(65535)));
      push_bases(5, 8);
      if (ph == 2) begin
        while (expected_sites.size() > 0 || pending_items.size() > 0 || in_valid)
          @(posedge clk_i);
        add_item(mk(OP_START));
        push_bases(5, 0);
      end
      settle();
      calm = 0;
    end
    if (errors == 0) $display("pwm_motif_site_scanner verification clean");
    else $display("pwm_motif_site_scanner verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("pwm_motif_site_scanner verification failed");
    $finish;
  end
endmodule

@@ sim.f @@
design/pwm_pkg.sv
design/pwm_front.sv
design/pwm_back.sv
design/pwm_motif_site_scanner.sv
dv/pwm_motif_site_scanner_tb.sv
